FILE: rtl/clds_pkg.sv
// ----------------------------------------------------------------------------
// clds_pkg - shared types and constants for the character shadow refresh
// Sizes of the two-row cell store, bus byte codes, and the decimal digit split.
// ----------------------------------------------------------------------------
`default_nettype none

package clds_pkg;

	localparam int COLUMNS = 16;
	localparam int ROWS    = 2;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int IDX_W   = $clog2(CELLS);
	localparam int COL_W   = ($clog2(COLUMNS) > 4) ? $clog2(COLUMNS) : 4;

	localparam logic [7:0] DIRTY_MARK = 8'h80;
	localparam logic [7:0] CHAR_MASK  = 8'h7f;
	localparam logic [7:0] ROW0_CMD   = 8'h80;
	localparam logic [7:0] ROW1_CMD   = 8'hc0;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} cell_wr_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last;
	} beat_t;

	// v / 10 for 8-bit v by reciprocal multiply, exact below 1029
	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd205;
		return p[15:11];
	endfunction

	function automatic logic [3:0] mod10(input logic [7:0] v);
		logic [4:0] q;
		logic [7:0] r;
		q = div10(v);
		r = v - ({3'd0, q} << 3) - ({3'd0, q} << 1);
		return r[3:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/clds_cell_file.sv
// ----------------------------------------------------------------------------
// clds_cell_file - two-row cell store
// One write port, one registered read port; all cells clear and clean at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module clds_cell_file (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire clds_pkg::cell_wr_t        wr,
	input  wire logic [clds_pkg::IDX_W-1:0] rd_addr,
	output logic [7:0]                     rd_data_q
);

	logic [7:0] cell_q [clds_pkg::CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < clds_pkg::CELLS; i++) begin
				cell_q[i] <= '0;
			end
		end else if (wr.en) begin
			cell_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= cell_q[rd_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/clds_ctrl.sv
// ----------------------------------------------------------------------------
// clds_ctrl - write and refresh sequencer
// Walks cells through one read/compare unit: writes compare and mark dirty,
// the refresh scan clears marks and hands out command and data beats.
// ----------------------------------------------------------------------------
`default_nettype none

module clds_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 func,
	input  wire logic                       row,
	input  wire logic [3:0]                 column,
	input  wire logic [7:0]                 char_value,
	output clds_pkg::cell_wr_t              wr,
	output logic [clds_pkg::IDX_W-1:0]      rd_addr,
	input  wire logic [7:0]                 rd_data,
	input  wire logic                       out_free,
	output logic                            out_load,
	output clds_pkg::beat_t                 out_beat
);

	localparam logic [1:0] FUNC_CHAR    = 2'd0;
	localparam logic [1:0] FUNC_DEC     = 2'd1;
	localparam logic [1:0] FUNC_REFRESH = 2'd2;

	localparam logic [clds_pkg::IDX_W-1:0] ROW1_BASE = clds_pkg::IDX_W'(clds_pkg::COLUMNS);
	localparam logic [clds_pkg::COL_W-1:0] COL_LAST  = clds_pkg::COL_W'(clds_pkg::COLUMNS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_RD,
		ST_WR_CMP,
		ST_SC_RD,
		ST_SC_CHK,
		ST_SC_PEND,
		ST_SC_CMD,
		ST_SC_END
	} state_t;

	state_t                     state_q;
	logic                       row_q;
	logic [clds_pkg::COL_W-1:0] col_q;
	logic [7:0]                 val_q;
	logic [7:0]                 tens_q;
	logic                       second_q;
	logic [6:0]                 cur_char_q;
	logic [6:0]                 pend_char_q;
	logic                       pend_q;

	logic       accept;
	logic       first_ok;
	logic       second_ok;
	logic [7:0] in_val;
	logic [7:0] in_tens;
	logic       at_last_cell;
	logic       differs;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign first_ok  = 32'(column) < 32'(clds_pkg::COLUMNS);
	assign second_ok = (func == FUNC_DEC) && (column != 4'd0)
		&& (32'(column) <= 32'(clds_pkg::COLUMNS));
	assign in_tens   = clds_pkg::DIGIT_ZERO + 8'(clds_pkg::div10(char_value));
	assign in_val    = (func == FUNC_CHAR) ? char_value
		: clds_pkg::DIGIT_ZERO + 8'(clds_pkg::mod10(char_value));

	assign rd_addr      = (row_q ? ROW1_BASE : '0) + clds_pkg::IDX_W'(col_q);
	assign at_last_cell = row_q && (col_q == COL_LAST);
	assign differs      = (rd_data != val_q);

	// the single compare unit decides every store update
	always_comb begin
		wr.addr = rd_addr;
		wr.en   = 1'b0;
		wr.data = rd_data & clds_pkg::CHAR_MASK;
		if (state_q == ST_WR_CMP) begin
			wr.en   = differs;
			wr.data = val_q | clds_pkg::DIRTY_MARK;
		end else if (state_q == ST_SC_CHK) begin
			wr.en = rd_data[7];
		end
	end

	always_comb begin
		out_load = 1'b0;
		out_beat = '0;
		unique case (state_q)
			ST_SC_PEND, ST_SC_END: begin
				out_load          = out_free && pend_q;
				out_beat.is_data  = 1'b1;
				out_beat.bus_byte = {1'b0, pend_char_q};
				out_beat.last     = (state_q == ST_SC_END);
			end
			ST_SC_CMD: begin
				out_load          = out_free;
				out_beat.bus_byte = (row_q ? clds_pkg::ROW1_CMD : clds_pkg::ROW0_CMD)
					+ 8'(col_q);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= 1'b0;
			col_q       <= '0;
			val_q       <= '0;
			tens_q      <= '0;
			second_q    <= 1'b0;
			cur_char_q  <= '0;
			pend_char_q <= '0;
			pend_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tens_q <= in_tens;
						pend_q <= 1'b0;
						if (func == FUNC_REFRESH) begin
							row_q    <= 1'b0;
							col_q    <= '0;
							second_q <= 1'b0;
							state_q  <= ST_SC_RD;
						end else if (func == FUNC_CHAR || func == FUNC_DEC) begin
							row_q <= row;
							if (first_ok) begin
								col_q    <= clds_pkg::COL_W'(column);
								val_q    <= in_val;
								second_q <= second_ok;
								state_q  <= ST_WR_RD;
							end else if (second_ok) begin
								// ones column off the display, tens still lands
								col_q    <= clds_pkg::COL_W'(column) - clds_pkg::COL_W'(1);
								val_q    <= in_tens;
								second_q <= 1'b0;
								state_q  <= ST_WR_RD;
							end
						end
					end
				end
				ST_WR_RD: begin
					state_q <= ST_WR_CMP;
				end
				ST_WR_CMP: begin
					if (second_q) begin
						second_q <= 1'b0;
						col_q    <= col_q - clds_pkg::COL_W'(1);
						val_q    <= tens_q;
						state_q  <= ST_WR_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SC_RD: begin
					state_q <= ST_SC_CHK;
				end
				ST_SC_CHK: begin
					if (rd_data[7]) begin
						cur_char_q <= rd_data[6:0];
						state_q    <= pend_q ? ST_SC_PEND : ST_SC_CMD;
					end else if (at_last_cell) begin
						state_q <= ST_SC_END;
					end else begin
						if (col_q == COL_LAST) begin
							row_q <= 1'b1;
							col_q <= '0;
						end else begin
							col_q <= col_q + clds_pkg::COL_W'(1);
						end
						state_q <= ST_SC_RD;
					end
				end
				ST_SC_PEND: begin
					// previous data beat goes out once a later dirty cell is known
					if (out_free) begin
						state_q <= ST_SC_CMD;
					end
				end
				ST_SC_CMD: begin
					if (out_free) begin
						pend_q      <= 1'b1;
						pend_char_q <= cur_char_q;
						if (at_last_cell) begin
							state_q <= ST_SC_END;
						end else begin
							if (col_q == COL_LAST) begin
								row_q <= 1'b1;
								col_q <= '0;
							end else begin
								col_q <= col_q + clds_pkg::COL_W'(1);
							end
							state_q <= ST_SC_RD;
						end
					end
				end
				ST_SC_END: begin
					if (!pend_q || out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/char_lcd_dirty_shadow_refresh.sv
// ----------------------------------------------------------------------------
// char_lcd_dirty_shadow_refresh - dirty-marked shadow store for a character LCD
// Input beats write characters or two-digit numbers into a two-row store;
// a refresh beat streams position commands and characters of dirty cells.
//
// s_* channel: one beat per operation, s_tuser selects character write,
// decimal write or refresh. s_tready is high only while the sequencer idles.
// m_* channel: one beat per bus byte, m_tuser flags a data byte, m_tlast
// marks the final byte of a refresh. Writes produce no m_* beats.
// A character write keeps s_tready low while its cell is read and
// compared, a decimal write while its ones and tens cells are (only the
// ones cell at column 0). A refresh reads the cells one at a time, and a
// dirty cell adds the states for its beats. The pace is set by the single
// read/compare path of the cell store.
// A single output register holds the next beat; while m_tready is low the
// scan halts at the next beat it wants to send and s_tready stays low.
// Reset (arst_n low) clears all cells to zero, clean, and drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_dirty_shadow_refresh (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // row[0], column[4:1], char_value[12:5], zero fill
	input  wire logic [1:0]  s_tuser,   // func[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // bus_byte[7:0]
	output logic             m_tuser,   // is_data
	output logic             m_tlast
);

	clds_pkg::cell_wr_t               wr;
	logic [clds_pkg::IDX_W-1:0]       rd_addr;
	logic [7:0]                       rd_data;
	logic                             out_free;
	logic                             out_load;
	clds_pkg::beat_t                  out_beat;
	clds_pkg::beat_t                  beat_q;
	logic                             m_tvalid_q;

	clds_cell_file u_cell_file (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data)
	);

	clds_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.func       (s_tuser),
		.row        (s_tdata[0]),
		.column     (s_tdata[4:1]),
		.char_value (s_tdata[12:5]),
		.wr         (wr),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_free   (out_free),
		.out_load   (out_load),
		.out_beat   (out_beat)
	);

	// output register frees up in the same cycle its beat is taken
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			beat_q <= out_beat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = beat_q.bus_byte;
	assign m_tuser  = beat_q.is_data;
	assign m_tlast  = beat_q.last;

endmodule

`default_nettype wire

FILE: dv/clds_refresh_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clds_refresh_checker - bus beat predictor and scoreboard
// Keeps its own copy of the two-row cell store with dirty marks, works out the
// command and character beats that every accepted refresh must stream, and
// compares each m_* beat field by field with the oldest beat still due.
// ----------------------------------------------------------------------------

package clds_tb_pkg;

	typedef enum logic [1:0] {
		FN_CHAR_WR = 2'd0,
		FN_DEC_WR  = 2'd1,
		FN_REFRESH = 2'd2,
		FN_UNUSED  = 2'd3
	} lcd_func_e;

endpackage

module clds_refresh_checker
	import clds_pkg::*;
	import clds_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // row[0], column[4:1], char_value[12:5], zero fill
	input  logic [1:0]  s_tuser,   // func[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // bus_byte[7:0]
	input  logic        m_tuser,   // is_data
	input  logic        m_tlast,
	output int          mismatches,
	output int          beats_pending,
	output int          beats_checked
);

	logic [7:0] shadow_cells [CELLS];
	beat_t      bus_beats_due [$];
	int         fail_tally;
	int         beat_tally;

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_tally++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function automatic void store_cell(input logic row, input int col, input logic [7:0] value);
		int idx;
		if (col >= COLUMNS)
			return;
		idx = int'(row) * COLUMNS + col;
		// compare includes the dirty mark, so a clean copy never equals a marked value
		if (shadow_cells[idx] != value)
			shadow_cells[idx] = value | DIRTY_MARK;
	endfunction

	function automatic void scan_dirty();
		int    idx;
		int    queued_before;
		beat_t b;
		queued_before = bus_beats_due.size();
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLUMNS; c++) begin
				idx = r * COLUMNS + c;
				if ((shadow_cells[idx] & DIRTY_MARK) != 0) begin
					shadow_cells[idx] = shadow_cells[idx] & CHAR_MASK;
					b.is_data  = 1'b0;
					b.bus_byte = ((r == 0) ? ROW0_CMD : ROW1_CMD) + 8'(c);
					b.last     = 1'b0;
					bus_beats_due.push_back(b);
					b.is_data  = 1'b1;
					b.bus_byte = shadow_cells[idx];
					bus_beats_due.push_back(b);
				end
			end
		end
		if (bus_beats_due.size() > queued_before) begin
			b = bus_beats_due.pop_back();
			b.last = 1'b1;
			bus_beats_due.push_back(b);
		end
	endfunction

	function automatic void apply_op(input lcd_func_e fn, input logic row, input logic [3:0] col,
			input logic [7:0] value);
		case (fn)
			FN_CHAR_WR: store_cell(row, int'(col), value);
			FN_DEC_WR: begin
				store_cell(row, int'(col), DIGIT_ZERO + 8'(value % 8'd10));
				// tens digit has no place left of column 0
				if (col != 4'd0)
					store_cell(row, int'(col) - 1, DIGIT_ZERO + 8'(value / 8'd10));
			end
			FN_REFRESH: scan_dirty();
			default: ;
		endcase
	endfunction

	function automatic void compare_beat();
		beat_t want;
		beat_tally++;
		if (bus_beats_due.size() == 0) begin
			fail_tally++;
			$display("%0t: unexpected beat, expected none, actual is_data=%0b byte=%02h last=%0b",
				$time, m_tuser, m_tdata, m_tlast);
		end else begin
			want = bus_beats_due.pop_front();
			check_field("is_data", want.is_data, m_tuser);
			check_field("bus_byte", want.bus_byte, m_tdata);
			check_field("last", want.last, m_tlast);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_cells[i])
				shadow_cells[i] = 8'h00;
			bus_beats_due.delete();
			fail_tally = 0;
			beat_tally = 0;
			mismatches <= 0;
			beats_pending <= 0;
			beats_checked <= 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_beat();
			if (s_tvalid && s_tready)
				apply_op(lcd_func_e'(s_tuser), s_tdata[0], s_tdata[4:1], s_tdata[12:5]);
			mismatches <= fail_tally;
			beats_pending <= bus_beats_due.size();
			beats_checked <= beat_tally;
		end
	end

endmodule

FILE: dv/tb_char_lcd_dirty_shadow_refresh.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_dirty_shadow_refresh - stimulus and verdict for the shadow refresh
// Drives directed and random character writes, decimal writes and refreshes
// with random idle bursts on both channels, one long bus hold against a full
// store, and drain pauses; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------

module tb_char_lcd_dirty_shadow_refresh;
	import clds_pkg::*;
	import clds_tb_pkg::*;

	localparam int RANDOM_OPS   = 57;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 150;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // row[0], column[4:1], char_value[12:5], zero fill
	logic [1:0]  s_tuser;   // func[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // bus_byte[7:0]
	logic        m_tuser;   // is_data
	logic        m_tlast;

	int mismatches;
	int beats_pending;
	int beats_checked;
	int ops_sent [4];
	int holds_asked;
	bit calm;
	int cycle_count = 0;

	char_lcd_dirty_shadow_refresh uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	clds_refresh_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.beats_pending (beats_pending),
		.beats_checked (beats_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still due", cycle_count, beats_pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// bus side pacing: random stall bursts plus the requested long hold
	initial begin : bus_pace
		int stall_left;
		int hold_left;
		int holds_served;
		stall_left = 0;
		hold_left = 0;
		holds_served = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// valid stays high from one op to the next unless an idle burst is taken
	task automatic offer(input lcd_func_e fn, input logic row, input logic [3:0] col,
			input logic [7:0] value);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, value, col, row};
		s_tuser  <= fn;
		do @(posedge clk); while (!s_tready);
		ops_sent[fn]++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (beats_pending != 0);
	endtask

	function automatic lcd_func_e pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return FN_CHAR_WR;
		else if (r < 75)
			return FN_DEC_WR;
		else if (r < 92)
			return FN_REFRESH;
		return FN_UNUSED;
	endfunction

	function automatic logic [7:0] pick_value();
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0: return 8'h41;
				1: return 8'hc1;
				2: return 8'h00;
				default: return 8'hff;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		arst_n      = 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= FN_CHAR_WR;
		holds_asked <= 0;
		calm        <= 1'b0;
		foreach (ops_sent[i])
			ops_sent[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty refresh, extremes, digit corner cases, compare on the mark
		offer(FN_REFRESH, 1'b0, 4'd0, 8'h00);
		offer(FN_CHAR_WR, 1'b0, 4'd0, 8'h00);
		offer(FN_CHAR_WR, 1'b1, 4'd15, 8'hff);
		offer(FN_CHAR_WR, 1'b0, 4'd0, 8'h41);
		offer(FN_CHAR_WR, 1'b0, 4'd0, 8'h41);
		offer(FN_DEC_WR, 1'b0, 4'd0, 8'd7);
		offer(FN_DEC_WR, 1'b1, 4'd5, 8'd255);
		offer(FN_DEC_WR, 1'b0, 4'd15, 8'd99);
		offer(FN_DEC_WR, 1'b1, 4'd1, 8'd0);
		offer(FN_UNUSED, 1'b1, 4'd10, 8'h5a);
		offer(FN_REFRESH, 1'b1, 4'd15, 8'hff);
		offer(FN_REFRESH, 1'b0, 4'd0, 8'h00);
		offer(FN_CHAR_WR, 1'b0, 4'd3, 8'h41);
		offer(FN_REFRESH, 1'b0, 4'd0, 8'h00);
		offer(FN_CHAR_WR, 1'b0, 4'd3, 8'h41);
		offer(FN_CHAR_WR, 1'b0, 4'd3, 8'hc1);
		offer(FN_CHAR_WR, 1'b0, 4'd3, 8'hc1);
		offer(FN_DEC_WR, 1'b1, 4'd8, 8'd100);
		offer(FN_UNUSED, 1'b0, 4'd5, 8'ha5);
		offer(FN_REFRESH, 1'b0, 4'd0, 8'h00);
		drain();

		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == 30) begin
				// write every cell, then let the bus sit still under a full refresh
				for (int cell_idx = 0; cell_idx < CELLS; cell_idx++)
					offer(FN_CHAR_WR, 1'(cell_idx / COLUMNS), 4'(cell_idx % COLUMNS),
						pick_value());
				holds_asked <= holds_asked + 1;
				offer(FN_REFRESH, 1'b0, 4'd0, 8'h00);
			end
			if (n == 45)
				drain();
			if (n == RANDOM_OPS - 25)
				calm <= 1'b1;
			offer(pick_func(), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), pick_value());
		end
		offer(FN_REFRESH, 1'b0, 4'd0, 8'h00);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d char writes, %0d decimal writes, %0d refreshes, %0d unused ops",
			ops_sent[FN_CHAR_WR], ops_sent[FN_DEC_WR], ops_sent[FN_REFRESH], ops_sent[FN_UNUSED]);
		$display("checked %0d bus beats, including a full-store refresh under a long bus hold",
			beats_checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
